### sv/tccw_pkg.sv
`default_nettype none
package tccw_pkg;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELL_COUNT    = ROWS * COLUMNS;
	localparam int MOVE_COUNT    = CELL_COUNT - COLUMNS;
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int COL_W         = $clog2(COLUMNS);
	localparam int ROW_W         = $clog2(ROWS);
	localparam int CELL_W        = 16;

	localparam int IDX_W = 11;
	localparam int POS_W = 11;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_TEXT_ATTR = 1'b0;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] DEFAULT_ATTR = 8'h07;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [7:0]       char_code;
		logic [IDX_W-1:0] cell_index;
	} in_beat_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor_pos;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
		logic             scrolled;
	} out_beat_t;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_PRINT,
		CMD_NEWLINE,
		CMD_BACKSPACE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        ch;
		logic [ADDR_W-1:0] addr;
		logic              in_range;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} q_rd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_FILL
	} state_t;

endpackage
`default_nettype wire

### sv/tccw_ram.sv
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/tccw_front.sv
`default_nettype none
module tccw_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tccw_pkg::in_beat_t in_data,
	input  wire logic               init_busy,
	input  wire logic               q_full,
	output tccw_pkg::q_wr_t         q_wr
);
	import tccw_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_new;
	logic accept;

	always_comb begin
		cmd_new.ch       = in_data.char_code;
		cmd_new.addr     = ADDR_W'(in_data.cell_index);
		cmd_new.in_range = 32'(in_data.cell_index) < 32'(CELL_COUNT);
		if (in_data.operation == OP_READ) begin
			cmd_new.kind = CMD_READ;
		end else if (in_data.char_code == CH_NEWLINE) begin
			cmd_new.kind = CMD_NEWLINE;
		end else if (in_data.char_code == CH_BACKSPACE) begin
			cmd_new.kind = CMD_BACKSPACE;
		end else begin
			cmd_new.kind = CMD_PRINT;
		end
	end

	assign in_stall = init_busy | (valid_s1 & q_full);
	assign accept   = in_valid & ~in_stall;
	assign q_wr.push = valid_s1 & ~q_full;
	assign q_wr.cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr.push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule
`default_nettype wire

### sv/tccw_queue.sv
`default_nettype none
module tccw_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tccw_pkg::q_wr_t q_wr,
	output logic                 q_full,
	input  wire logic            q_pop,
	output tccw_pkg::q_rd_t      q_rd
);
	import tccw_pkg::*;

	localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign q_full    = count_q == FULL_COUNT;
	assign q_rd.avail = count_q != '0;
	assign q_rd.cmd   = mem_q[rd_ptr_q];
	assign do_push   = q_wr.push & ~q_full;
	assign do_pop    = q_pop & q_rd.avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

endmodule
`default_nettype wire

### sv/tccw_back.sv
`default_nettype none
module tccw_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tccw_pkg::q_rd_t q_rd,
	output logic                 q_pop,
	input  wire logic [7:0]      attr,
	output logic                 init_busy,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output tccw_pkg::out_beat_t  out_data
);
	import tccw_pkg::*;

	localparam logic [ADDR_W-1:0] A_LAST_CELL = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] A_MOVE      = ADDR_W'(MOVE_COUNT);
	localparam logic [ADDR_W-1:0] A_COLUMNS   = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] A_LAST_BASE = ADDR_W'(LAST_ROW_BASE);
	localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic              in_range_q, in_range_d;
	logic              cp_valid_s1, cp_valid_d;
	logic [ADDR_W-1:0] cp_addr_s1, cp_addr_d;
	logic              res_valid_q;
	out_beat_t         res_q, res_d;
	logic              res_load;
	logic              res_free;
	logic              start;

	logic [COL_W-1:0]  step_col;
	logic [ROW_W-1:0]  step_row;
	logic [ADDR_W-1:0] step_pos;
	logic              step_scroll;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign res_free  = ~res_valid_q | ~out_stall;
	assign start     = (state_q == ST_IDLE) & q_rd.avail & res_free;
	assign init_busy = state_q == ST_INIT;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_comb begin
		step_col    = col_q;
		step_row    = row_q;
		step_pos    = pos_q;
		step_scroll = 1'b0;
		case (q_rd.cmd.kind)
			CMD_PRINT: begin
				if (col_q == LAST_COL) begin
					step_col = '0;
					if (row_q == LAST_ROW) begin
						step_scroll = 1'b1;
						step_pos    = A_LAST_BASE;
					end else begin
						step_row = row_q + 1'b1;
						step_pos = pos_q + 1'b1;
					end
				end else begin
					step_col = col_q + 1'b1;
					step_pos = pos_q + 1'b1;
				end
			end
			CMD_NEWLINE: begin
				step_col = '0;
				if (row_q == LAST_ROW) begin
					step_scroll = 1'b1;
					step_pos    = A_LAST_BASE;
				end else begin
					step_row = row_q + 1'b1;
					step_pos = pos_q - ADDR_W'(col_q) + A_COLUMNS;
				end
			end
			CMD_BACKSPACE: begin
				if (col_q != '0) begin
					step_col = col_q - 1'b1;
					step_pos = pos_q - 1'b1;
				end else if (row_q != '0) begin
					step_row = row_q - 1'b1;
					step_col = LAST_COL;
					step_pos = pos_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == A_LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (q_rd.cmd.kind == CMD_READ) begin
						state_d = ST_READ;
					end else if (step_scroll) begin
						state_d = ST_COPY;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				if (cnt_q == A_MOVE) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (cnt_q == A_LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_comb begin
		cnt_d      = cnt_q;
		col_d      = col_q;
		row_d      = row_q;
		pos_d      = pos_q;
		in_range_d = in_range_q;
		cp_valid_d = 1'b0;
		cp_addr_d  = cp_addr_s1;
		q_pop      = 1'b0;
		res_load   = 1'b0;
		res_d      = '0;
		res_d.cursor_pos = POS_W'(pos_q);
		ram_we     = 1'b0;
		ram_waddr  = cnt_q;
		ram_wdata  = {attr, CH_SPACE};
		ram_re     = 1'b0;
		ram_raddr  = q_rd.cmd.addr;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {DEFAULT_ATTR, CH_SPACE};
				cnt_d     = (cnt_q == A_LAST_CELL) ? '0 : cnt_q + 1'b1;
			end
			ST_IDLE: begin
				if (start) begin
					q_pop = 1'b1;
					if (q_rd.cmd.kind == CMD_READ) begin
						ram_re     = q_rd.cmd.in_range;
						in_range_d = q_rd.cmd.in_range;
					end else begin
						col_d = step_col;
						row_d = step_row;
						pos_d = step_pos;
						ram_we = q_rd.cmd.kind != CMD_NEWLINE;
						if (q_rd.cmd.kind == CMD_BACKSPACE) begin
							ram_waddr = step_pos;
						end else begin
							ram_waddr = pos_q;
							ram_wdata = {attr, q_rd.cmd.ch};
						end
						if (step_scroll) begin
							cnt_d = '0;
						end else begin
							res_load         = 1'b1;
							res_d.cursor_pos = POS_W'(step_pos);
						end
					end
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				if (in_range_q) begin
					res_d.cell_char = ram_rdata[7:0];
					res_d.cell_attr = ram_rdata[15:8];
				end
			end
			ST_COPY: begin
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
				if (cnt_q != A_MOVE) begin
					ram_re     = 1'b1;
					ram_raddr  = cnt_q + A_COLUMNS;
					cp_valid_d = 1'b1;
					cp_addr_d  = cnt_q;
					cnt_d      = cnt_q + 1'b1;
				end
			end
			ST_FILL: begin
				ram_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == A_LAST_CELL) begin
					res_load       = 1'b1;
					res_d.scrolled = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			cp_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			col_q       <= col_d;
			row_q       <= row_d;
			pos_q       <= pos_d;
			cp_valid_s1 <= cp_valid_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		in_range_q <= in_range_d;
		cp_addr_s1 <= cp_addr_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

### sv/text_console_char_writer_unit.sv
// A beat passes the front register and the queue to the back end, which registers its
// result; a read beat also waits in ST_READ for the screen data. Puts go at one a
// cycle while the output is not stalled; a read or a scroll holds the back end. A put
// that scrolls copies the screen up one cell a cycle and then clears the bottom row.
// After reset every cell of the screen is cleared, one cell a cycle, with in_stall high
// throughout; the text attribute resets to 7 and the cursor to the top left.
`default_nettype none
module text_console_char_writer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire tccw_pkg::in_beat_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tccw_pkg::out_beat_t                 out_data,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tccw_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tccw_pkg::PDATA_W-1:0]   pwdata,
	output logic      [tccw_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready
);
	import tccw_pkg::*;

	logic [7:0] attr_q;
	logic       init_busy;
	logic       q_full;
	logic       q_pop;
	q_wr_t      q_wr;
	q_rd_t      q_rd;
	logic       attr_sel;

	assign pready   = 1'b1;
	assign attr_sel = paddr[PADDR_W-1] == REG_TEXT_ATTR;
	assign prdata   = attr_sel ? PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= DEFAULT_ATTR;
		end else if (psel && penable && pwrite && pready && attr_sel) begin
			attr_q <= pwdata[7:0];
		end
	end

	tccw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.init_busy(init_busy),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	tccw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_wr  (q_wr),
		.q_full(q_full),
		.q_pop (q_pop),
		.q_rd  (q_rd)
	);

	tccw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.q_pop    (q_pop),
		.attr     (attr_q),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
`default_nettype wire
